/* rtl/core/m3i_pkg.sv */
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants and types for the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
`default_nettype none

package m3i_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // control word that travels beside the data in every stage
    typedef struct packed {
        logic valid;
        logic singular;
    } t_ctl;

endpackage

`default_nettype wire

/* rtl/core/m3i_div_lane.sv */
// ----------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider for one inverse element: one quotient bit per
// stage, overflow check first, then saturation and sign in a last register.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_div_lane #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire [2*ELEM_WIDTH+2*FRAC_BITS-1:0] i_num,
    input  wire [3*ELEM_WIDTH:0]         i_den,
    input  wire                          i_neg,
    output logic signed [ELEM_WIDTH-1:0] o_q,
    output logic                         o_clip
);

    localparam int E  = ELEM_WIDTH;
    localparam int NW = 2*E + 2*FRAC_BITS;
    localparam int DW = 3*E + 1;
    localparam int CW = 4*E + 2;
    localparam int NS = E + 2;

    logic [NW-1:0] r_rem [NS];
    logic [DW-1:0] r_den [NS];
    logic [E:0]    r_q   [NS];
    logic          r_ovf [NS];
    logic          r_neg [NS];

    for (genvar s = 0; s < NS; s++) begin : g_step
        localparam int K = E + 1 - s;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [E:0]    q_in;
        logic          ovf_in;
        logic          neg_in;
        logic [CW-1:0] shd;
        logic          ge;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
            assign ovf_in = 1'b0;
            assign neg_in = i_neg;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign q_in   = r_q[s-1];
            assign ovf_in = r_ovf[s-1];
            assign neg_in = r_neg[s-1];
        end

        assign shd = CW'(den_in) << K;
        assign ge  = CW'(rem_in) >= shd;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= den_in;
                r_neg[s] <= neg_in;
                if (s == 0) begin
                    r_rem[s] <= rem_in;
                    r_q[s]   <= q_in;
                    r_ovf[s] <= ge;
                end else begin
                    r_ovf[s] <= ovf_in;
                    if (ge) begin
                        r_rem[s] <= rem_in - NW'(shd);
                        r_q[s]   <= q_in | ((E+1)'(1) << K);
                    end else begin
                        r_rem[s] <= rem_in;
                        r_q[s]   <= q_in;
                    end
                end
            end
        end
    end

    logic [E:0] lim;
    logic       over;
    logic [E:0] mag;

    always_comb begin
        lim  = r_neg[NS-1] ? ((E+1)'(1) << (E-1)) : (((E+1)'(1) << (E-1)) - (E+1)'(1));
        over = r_ovf[NS-1] || (r_q[NS-1] > lim);
        mag  = over ? lim : r_q[NS-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q    <= r_neg[NS-1] ? E'((~mag) + (E+1)'(1)) : E'(mag);
            o_clip <= over;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/matrix3x3_inverse_core.sv */
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// Inverse of a 3x3 signed fixed-point matrix: cofactors, determinant,
// adjugate over determinant, truncated and saturated per element.
//
//   channel | direction | signals
//   in      | slave     | i_in_valid / o_in_ready, i_m00 .. i_m22
//   out     | master    | o_out_valid / i_out_ready, o_inv00 .. o_inv22,
//           |           | o_singular, o_clipped
//
// One matrix per cycle while the output is not stalled; six arithmetic stages,
// then ELEM_WIDTH + 3 divider stages (overflow check, quotient bits, saturation).
// Reset clears the stage control words (valid and singular bits) only.
// A stalled output freezes the whole pipe; o_in_ready drops in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3x3_inverse_core
    import m3i_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire signed [ELEM_WIDTH-1:0]  i_m00,
    input  wire signed [ELEM_WIDTH-1:0]  i_m10,
    input  wire signed [ELEM_WIDTH-1:0]  i_m20,
    input  wire signed [ELEM_WIDTH-1:0]  i_m01,
    input  wire signed [ELEM_WIDTH-1:0]  i_m11,
    input  wire signed [ELEM_WIDTH-1:0]  i_m21,
    input  wire signed [ELEM_WIDTH-1:0]  i_m02,
    input  wire signed [ELEM_WIDTH-1:0]  i_m12,
    input  wire signed [ELEM_WIDTH-1:0]  i_m22,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic signed [ELEM_WIDTH-1:0] o_inv00,
    output logic signed [ELEM_WIDTH-1:0] o_inv10,
    output logic signed [ELEM_WIDTH-1:0] o_inv20,
    output logic signed [ELEM_WIDTH-1:0] o_inv01,
    output logic signed [ELEM_WIDTH-1:0] o_inv11,
    output logic signed [ELEM_WIDTH-1:0] o_inv21,
    output logic signed [ELEM_WIDTH-1:0] o_inv02,
    output logic signed [ELEM_WIDTH-1:0] o_inv12,
    output logic signed [ELEM_WIDTH-1:0] o_inv22,
    output logic                         o_singular,
    output logic                         o_clipped
);

    localparam int E   = ELEM_WIDTH;
    localparam int NW  = 2*E + 2*FRAC_BITS;
    localparam int DTW = 3*E + 2;
    localparam int NC  = E + 9;
    localparam int SING_STAGE = 5;

    logic en;
    t_ctl r_ctl [NC];
    t_ctl n_ctl [NC];

    assign en         = !r_ctl[NC-1].valid || i_out_ready;
    assign o_in_ready = en;

    // stage 1: input capture
    logic signed [E-1:0] r_a [3][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a[0][0] <= i_m00; r_a[1][0] <= i_m10; r_a[2][0] <= i_m20;
            r_a[0][1] <= i_m01; r_a[1][1] <= i_m11; r_a[2][1] <= i_m21;
            r_a[0][2] <= i_m02; r_a[1][2] <= i_m12; r_a[2][2] <= i_m22;
        end
    end

    // stage 2: minor products
    logic signed [2*E-1:0] r_pp [3][3];
    logic signed [2*E-1:0] r_pq [3][3];
    logic signed [E-1:0]   r_row2 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pp[r][c] <= r_a[(r+1)%3][(c+1)%3] * r_a[(r+2)%3][(c+2)%3];
                    r_pq[r][c] <= r_a[(r+2)%3][(c+1)%3] * r_a[(r+1)%3][(c+2)%3];
                end
                r_row2[r] <= r_a[0][r];
            end
        end
    end

    // stage 3: cofactors
    logic signed [2*E:0] r_cof3 [3][3];
    logic signed [E-1:0] r_row3 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_cof3[r][c] <= (2*E+1)'(r_pp[r][c]) - (2*E+1)'(r_pq[r][c]);
                end
                r_row3[r] <= r_row2[r];
            end
        end
    end

    // stage 4: determinant partial products, cofactor split in halves
    logic signed [2*E:0] r_plo [3];
    logic signed [2*E:0] r_phi [3];
    logic signed [2*E:0] r_cof4 [3][3];
    logic signed [E:0]   lo_op [3];
    logic signed [E:0]   hi_op [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            lo_op[c] = $signed({1'b0, r_cof3[0][c][E-1:0]});
            hi_op[c] = $signed(r_cof3[0][c][2*E:E]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_plo[c] <= r_row3[c] * lo_op[c];
                r_phi[c] <= r_row3[c] * hi_op[c];
            end
            r_cof4 <= r_cof3;
        end
    end

    // stage 5: determinant sum
    logic signed [DTW-1:0] r_det;
    logic signed [2*E:0]   r_cof5 [3][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det <= (DTW'(r_phi[0]) <<< E) + DTW'(r_plo[0])
                   + (DTW'(r_phi[1]) <<< E) + DTW'(r_plo[1])
                   + (DTW'(r_phi[2]) <<< E) + DTW'(r_plo[2]);
            r_cof5 <= r_cof4;
        end
    end

    // stage 6: magnitudes and quotient signs, adjugate transpose
    logic [NW-1:0]    r_num [3][3];
    logic [3*E:0]     r_den;
    logic             r_neg [3][3];
    logic [DTW-1:0]   det_abs;
    logic [2*E:0]     cof_abs [3][3];

    always_comb begin
        det_abs = r_det[DTW-1] ? DTW'(-r_det) : DTW'(r_det);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                cof_abs[r][c] = r_cof5[r][c][2*E] ? (2*E+1)'(-r_cof5[r][c])
                                                  : (2*E+1)'(r_cof5[r][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= det_abs[3*E:0];
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_num[r][c] <= {cof_abs[c][r][2*E-1:0], {(2*FRAC_BITS){1'b0}}};
                    r_neg[r][c] <= r_cof5[c][r][2*E] ^ r_det[DTW-1];
                end
            end
        end
    end

    // divider lanes
    logic signed [E-1:0] q [3][3];
    logic                clip [3][3];

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            m3i_div_lane #(
                .ELEM_WIDTH (ELEM_WIDTH),
                .FRAC_BITS  (FRAC_BITS)
            ) u_lane (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_num  (r_num[r][c]),
                .i_den  (r_den),
                .i_neg  (r_neg[r][c]),
                .o_q    (q[r][c]),
                .o_clip (clip[r][c])
            );
        end
    end

    // control pipe
    always_comb begin
        for (int s = 0; s < NC; s++) begin
            if (s == 0) begin
                n_ctl[s].valid    = i_in_valid;
                n_ctl[s].singular = 1'b0;
            end else if (s == SING_STAGE) begin
                n_ctl[s].valid    = r_ctl[s-1].valid;
                n_ctl[s].singular = (r_det == '0);
            end else begin
                n_ctl[s] = r_ctl[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NC; s++) begin
                r_ctl[s] <= '0;
            end
        end else if (en) begin
            r_ctl <= n_ctl;
        end
    end

    logic sing;
    logic any_clip;

    always_comb begin
        sing     = r_ctl[NC-1].singular;
        any_clip = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                any_clip = any_clip | clip[r][c];
            end
        end
    end

    assign o_out_valid = r_ctl[NC-1].valid;
    assign o_singular  = sing;
    assign o_clipped   = !sing && any_clip;
    assign o_inv00 = sing ? '0 : q[0][0];
    assign o_inv10 = sing ? '0 : q[1][0];
    assign o_inv20 = sing ? '0 : q[2][0];
    assign o_inv01 = sing ? '0 : q[0][1];
    assign o_inv11 = sing ? '0 : q[1][1];
    assign o_inv21 = sing ? '0 : q[2][1];
    assign o_inv02 = sing ? '0 : q[0][2];
    assign o_inv12 = sing ? '0 : q[1][2];
    assign o_inv22 = sing ? '0 : q[2][2];

endmodule

`default_nettype wire

/* rtl/core/m3i_checker.sv */
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks for the matrix inverse core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_checker
    import m3i_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_in_ready,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input wire [ELEM_WIDTH-1:0] o_inv00,
    input wire [ELEM_WIDTH-1:0] o_inv11,
    input wire [ELEM_WIDTH-1:0] o_inv22,
    input wire                  o_singular,
    input wire                  o_clipped
);

    a_ready_tracks_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_inv00)
            && $stable(o_singular) && $stable(o_clipped))
        else $error("stalled result changed");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> !o_clipped && o_inv00 == '0
            && o_inv11 == '0 && o_inv22 == '0)
        else $error("singular result not cleared");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind matrix3x3_inverse_core m3i_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_m3i_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_inv00     (o_inv00),
    .o_inv11     (o_inv11),
    .o_inv22     (o_inv22),
    .o_singular  (o_singular),
    .o_clipped   (o_clipped)
);

`default_nettype wire
